// ===== rtl/stms_pkg.sv =====
// Package with the shared types, codes and sizes of the sorted table search block.
`timescale 1ns / 1ps

package stms_pkg;

    localparam int TABLE_DEPTH = 4096;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int ISBN_W      = 31;
    localparam int TYPE_W      = 2;
    localparam int KEY_W       = ISBN_W + TYPE_W;
    localparam int TOTAL_W     = 32;

    typedef logic [1:0]         kind_t;
    typedef logic [KEY_W-1:0]   key_t;
    typedef logic [ADDR_W-1:0]  addr_t;
    typedef logic [CNT_W-1:0]   cnt_t;
    typedef logic [TOTAL_W-1:0] total_t;

    localparam kind_t KIND_LOAD   = 2'd0;
    localparam kind_t KIND_SEARCH = 2'd1;
    localparam kind_t KIND_CLEAR  = 2'd2;

    localparam total_t TOTAL_MAX = '1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INS_RD,
        ST_INS_CMP,
        ST_SRCH_RD,
        ST_SRCH_CMP,
        ST_RESP
    } state_t;

    // Request from the sequencer to the record memory.
    typedef struct packed {
        logic  we;
        addr_t waddr;
        key_t  wdata;
        logic  re;
        addr_t raddr;
    } mem_req_t;

    // Result handed from the sequencer to the output register.
    typedef struct packed {
        logic   found;
        total_t found_total;
        logic   load_dropped;
    } result_t;

endpackage

// ===== rtl/stms_if.sv =====
// Handshake interfaces for the input item channel and the result channel.
`timescale 1ns / 1ps

interface stms_item_if;
    logic                         valid;
    logic                         ready;
    logic [1:0]                   kind;
    logic [30:0]                  isbn;
    logic [1:0]                   book_type;

    modport source (output valid, output kind, output isbn, output book_type, input ready);
    modport sink   (input valid, input kind, input isbn, input book_type, output ready);
endinterface

interface stms_result_if;
    logic        valid;
    logic        ready;
    logic        found;
    logic [31:0] found_total;
    logic        load_dropped;

    modport source (output valid, output found, output found_total, output load_dropped,
                    input ready);
    modport sink   (input valid, input found, input found_total, input load_dropped,
                    output ready);
endinterface

// ===== rtl/stms_store.sv =====
// Record memory: one write port and one registered read port.
`timescale 1ns / 1ps

module stms_store
    import stms_pkg::*;
(
    input  logic     clk,
    input  mem_req_t req,
    output key_t     rd_data
);

    key_t mem [TABLE_DEPTH];
    key_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.waddr] <= req.wdata;
        end
        if (req.re)
        begin
            rd_data_reg <= mem[req.raddr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/stms_ctrl.sv =====
// Sequencer with the shared key comparator: sorted insertion, binary search and counters.
`timescale 1ns / 1ps

module stms_ctrl
    import stms_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    stms_item_if.sink     item,
    output mem_req_t      mem_req,
    input  key_t          rd_data,
    output logic          res_valid,
    output result_t       res,
    input  logic          res_ready
);

    state_t state_reg, state_next;
    cnt_t   count_reg, count_next;
    total_t counter_reg, counter_next;
    addr_t  idx_reg, idx_next;
    cnt_t   lo_reg, lo_next;
    cnt_t   hi_reg, hi_next;
    addr_t  mid_reg, mid_next;
    key_t   key_reg, key_next;
    logic   hit_reg, hit_next;
    logic   drop_reg, drop_next;

    logic   in_fire;
    key_t   in_key;
    logic   rd_lt_key;
    logic   rd_eq_key;
    cnt_t   mid_wide;

    assign in_fire = item.valid && item.ready;
    assign in_key  = {item.isbn, item.book_type};

    // The one comparator, shared by insertion and search.
    assign rd_lt_key = rd_data < key_reg;
    assign rd_eq_key = rd_data == key_reg;

    assign mid_wide = lo_reg + ((hi_reg - lo_reg) >> 1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            counter_reg <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            counter_reg <= counter_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg  <= idx_next;
        lo_reg   <= lo_next;
        hi_reg   <= hi_next;
        mid_reg  <= mid_next;
        key_reg  <= key_next;
        hit_reg  <= hit_next;
        drop_reg <= drop_next;
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    if (item.kind == KIND_LOAD)
                    begin
                        state_next = (count_reg >= cnt_t'(TABLE_DEPTH)) ? ST_RESP : ST_INS_RD;
                    end
                    else if (item.kind == KIND_SEARCH)
                    begin
                        state_next = ST_SRCH_RD;
                    end
                end
            end
            ST_INS_RD:
            begin
                state_next = (idx_reg == '0) ? ST_IDLE : ST_INS_CMP;
            end
            ST_INS_CMP:
            begin
                state_next = (rd_lt_key || rd_eq_key) ? ST_IDLE : ST_INS_RD;
            end
            ST_SRCH_RD:
            begin
                state_next = (lo_reg >= hi_reg) ? ST_RESP : ST_SRCH_CMP;
            end
            ST_SRCH_CMP:
            begin
                state_next = ST_SRCH_RD;
            end
            ST_RESP:
            begin
                if (res_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Datapath and memory controls.
    always_comb
    begin
        count_next   = count_reg;
        counter_next = counter_reg;
        idx_next     = idx_reg;
        lo_next      = lo_reg;
        hi_next      = hi_reg;
        mid_next     = mid_reg;
        key_next     = key_reg;
        hit_next     = hit_reg;
        drop_next    = drop_reg;
        mem_req      = '0;
        item.ready   = 1'b0;
        res_valid    = 1'b0;
        res.found        = hit_reg && !drop_reg;
        res.found_total  = counter_reg;
        res.load_dropped = drop_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                item.ready = 1'b1;
                if (in_fire)
                begin
                    key_next  = in_key;
                    idx_next  = count_reg[ADDR_W-1:0];
                    lo_next   = '0;
                    hi_next   = count_reg;
                    hit_next  = 1'b0;
                    drop_next = (item.kind == KIND_LOAD);
                    if (item.kind == KIND_CLEAR)
                    begin
                        count_next   = '0;
                        counter_next = '0;
                    end
                end
            end
            ST_INS_RD:
            begin
                if (idx_reg == '0)
                begin
                    mem_req.we    = 1'b1;
                    mem_req.waddr = idx_reg;
                    mem_req.wdata = key_reg;
                    count_next    = count_reg + cnt_t'(1);
                end
                else
                begin
                    mem_req.re    = 1'b1;
                    mem_req.raddr = idx_reg - addr_t'(1);
                end
            end
            ST_INS_CMP:
            begin
                // Entries greater than the new key move up one place; equal ones stay below.
                mem_req.we    = 1'b1;
                mem_req.waddr = idx_reg;
                if (rd_lt_key || rd_eq_key)
                begin
                    mem_req.wdata = key_reg;
                    count_next    = count_reg + cnt_t'(1);
                end
                else
                begin
                    mem_req.wdata = rd_data;
                    idx_next      = idx_reg - addr_t'(1);
                end
            end
            ST_SRCH_RD:
            begin
                if (lo_reg >= hi_reg)
                begin
                    if (hit_reg && counter_reg != TOTAL_MAX)
                    begin
                        counter_next = counter_reg + total_t'(1);
                    end
                end
                else
                begin
                    mid_next      = mid_wide[ADDR_W-1:0];
                    mem_req.re    = 1'b1;
                    mem_req.raddr = mid_wide[ADDR_W-1:0];
                end
            end
            ST_SRCH_CMP:
            begin
                // A present key is always probed on its way to the lower bound.
                if (rd_eq_key)
                begin
                    hit_next = 1'b1;
                end
                if (rd_lt_key)
                begin
                    lo_next = cnt_t'(mid_reg) + cnt_t'(1);
                end
                else
                begin
                    hi_next = cnt_t'(mid_reg);
                end
            end
            ST_RESP:
            begin
                res_valid = 1'b1;
            end
            default:
            begin
                mem_req = '0;
            end
        endcase
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= cnt_t'(TABLE_DEPTH))
        else $error("record count above table depth");

    a_search_window: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SRCH_CMP) |-> (lo_reg < hi_reg && hi_reg <= count_reg))
        else $error("search window out of range");

    a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && item.kind == KIND_CLEAR) |=> (count_reg == '0 && counter_reg == '0))
        else $error("clear did not empty the table");

    a_counter_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_fire && item.kind == KIND_CLEAR) |=> counter_reg >= $past(counter_reg))
        else $error("found count went down without a clear");
`endif

endmodule

// ===== rtl/sorted_table_membership_search.sv =====
// Top level of the sorted book table: sequencer, record memory and result register.
// A search probes the sorted records by binary search, each probe being a memory read and
// a compare through the shared comparator. A load moves the entries above its key up one
// place, one entry a pass through the same read port; a dropped load goes straight to the
// result. One item is in work at a time, and the result register lets the next item enter
// while a result waits.
// Reset (rst_n, asynchronous, active low) empties the table and zeroes the found count.
`timescale 1ns / 1ps

module sorted_table_membership_search
    import stms_pkg::*;
(
    input  logic           clk,
    input  logic           rst_n,
    stms_item_if.sink      item,
    stms_result_if.source  result
);

    mem_req_t mem_req;
    key_t     rd_data;
    logic     res_valid;
    result_t  res;
    logic     res_ready;

    logic     out_valid_reg;
    result_t  out_reg;

    stms_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (item),
        .mem_req   (mem_req),
        .rd_data   (rd_data),
        .res_valid (res_valid),
        .res       (res),
        .res_ready (res_ready)
    );

    stms_store u_store (
        .clk     (clk),
        .req     (mem_req),
        .rd_data (rd_data)
    );

    assign res_ready = !out_valid_reg || result.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_ready)
        begin
            out_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_ready && res_valid)
        begin
            out_reg <= res;
        end
    end

    assign result.valid        = out_valid_reg;
    assign result.found        = out_reg.found;
    assign result.found_total  = out_reg.found_total;
    assign result.load_dropped = out_reg.load_dropped;

endmodule
